// File: rtl/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
package swm_pkg;

  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

  localparam int QUEUE_DEPTH = 2;
  typedef logic [$clog2(QUEUE_DEPTH+1)-1:0] qcount_t;

endpackage

// File: rtl/swm_cell.sv
// One cell of the running-maximum chain: max of the last (index+1) samples.
module swm_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] prev,
  output logic signed [SAMPLE_BITS-1:0] peak,
  output logic signed [SAMPLE_BITS-1:0] peak_next
);

  assign peak_next = (prev > sample) ? prev : sample;

  always_ff @(posedge clk) begin
    if (en) begin
      peak <= peak_next;
    end
  end

endmodule

// File: rtl/swm_outq.sv
// Two-entry result queue between the cell chain and the output channel.
module swm_outq #(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] dout
);
  import swm_pkg::*;

  localparam qcount_t FULL = qcount_t'(QUEUE_DEPTH);

  qcount_t          cnt;
  qcount_t          cnt_after_pop;
  logic             pop;
  logic [WIDTH-1:0] slot0;
  logic [WIDTH-1:0] slot1;

  assign pop           = (cnt != '0) && out_ready;
  assign space         = (cnt != FULL) || out_ready;
  assign cnt_after_pop = cnt - qcount_t'(pop);
  assign out_valid     = (cnt != '0);
  assign dout          = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_after_pop + qcount_t'(push);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt_after_pop == '0)) begin
      slot0 <= din;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && (cnt_after_pop != '0)) begin
      slot1 <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt_after_pop != FULL))
    else $error("result queue overflow");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && cnt == qcount_t'(1)) |=> (cnt == FULL))
    else $error("result queue count lost a beat");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(dout))
    else $error("queued head changed while stalled");

endmodule

// File: rtl/sliding_window_maximum_top.sv
// Top level of the sliding window maximum block.
//
// Input channel s_*: one signed sample per beat in s_tdata, s_tlast marks the
// last sample of a sequence. Output channel m_*: one beat per input sample once
// the sequence has seen window_length samples; m_tdata is the maximum of the
// last window_length samples, m_tlast marks the result of the sequence's last
// sample. A sequence shorter than the window gives no beat; state clears after
// every s_tlast either way.
// cfg_*: writes window_length (0 acts as 1, above MAX_WINDOW acts as
// MAX_WINDOW); cfg_ready is always high, write only while idle.
// A chain of MAX_WINDOW cells holds the running maxima of the last 1..N samples
// and updates all cells in the cycle a sample is accepted, so the block takes
// one sample per clock while s_tready is high. The result is registered into a
// two-entry queue. While m_tready is low the queue holds up to two results and
// s_tready drops only once both are waiting.
// Reset (rst, synchronous) clears the queue and the sequence state and sets
// window_length to 3; no clearing pass is needed.
module sliding_window_maximum_top #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swm_pkg::CFG_BITS-1:0]          cfg_data,   // window_length
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,    // sample
  input  logic                                  s_tlast,    // end_of_sequence
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,    // window_max
  output logic                                  m_tlast     // final_result
);
  import swm_pkg::*;

  localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int IW = $clog2(MAX_WINDOW);

  logic [CFG_BITS-1:0] window_length;
  logic [LW-1:0]       w_eff;
  logic [LW-1:0]       alive;
  logic [LW-1:0]       alive_next;
  logic [LW:0]         alive_inc;
  logic [LW-1:0]       pos;
  logic [LW:0]         pos_inc;
  logic                filled;
  logic                filled_next;
  logic [IW-1:0]       sel;
  logic                s_fire;
  logic                q_space;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] peak      [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] peak_next [MAX_WINDOW];
  logic [SAMPLE_BITS:0]          q_din;
  logic [SAMPLE_BITS:0]          q_dout;

  assign cfg_ready = 1'b1;
  assign s_tready  = q_space;
  assign s_fire    = s_tvalid && s_tready;
  assign sample    = s_tdata[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_length <= cfg_data;
    end
  end

  always_comb begin
    if (window_length == '0) begin
      w_eff = LW'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      w_eff = LW'(MAX_WINDOW);
    end else begin
      w_eff = LW'(window_length);
    end
  end

  // live candidates are always the newest `alive` samples
  assign alive_inc   = {1'b0, alive} + (LW+1)'(1);
  assign alive_next  = (alive_inc > {1'b0, w_eff}) ? w_eff : alive_inc[LW-1:0];
  assign sel         = IW'(alive_next - LW'(1));
  assign pos_inc     = {1'b0, pos} + (LW+1)'(1);
  assign filled_next = filled || (pos_inc >= {1'b0, w_eff});

  always_ff @(posedge clk) begin
    if (rst) begin
      alive  <= '0;
      pos    <= '0;
      filled <= 1'b0;
    end else if (s_fire) begin
      if (s_tlast) begin
        alive  <= '0;
        pos    <= '0;
        filled <= 1'b0;
      end else begin
        alive  <= alive_next;
        filled <= filled_next;
        if (!filled) begin
          pos <= pos_inc[LW-1:0];
        end
      end
    end
  end

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] prev;
    if (k == 0) begin : g_head
      assign prev = sample;
    end else begin : g_link
      assign prev = peak[k-1];
    end
    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .en       (s_fire),
      .sample   (sample),
      .prev     (prev),
      .peak     (peak[k]),
      .peak_next(peak_next[k])
    );
  end

  assign q_din = {s_tlast, peak_next[sel]};

  swm_outq #(
    .WIDTH(SAMPLE_BITS + 1)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (s_fire && filled_next),
    .din      (q_din),
    .space    (q_space),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .dout     (q_dout)
  );

  assign m_tdata = DW'(q_dout[SAMPLE_BITS-1:0]);
  assign m_tlast = q_dout[SAMPLE_BITS];

  a_alive_bound: assert property (@(posedge clk) disable iff (rst)
    alive <= LW'(MAX_WINDOW))
    else $error("live count beyond cell chain");

  a_seq_clear: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tlast) |=> (alive == '0 && !filled && pos == '0))
    else $error("sequence state not cleared");

  a_alive_grows: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !s_tlast) |=> (alive != '0))
    else $error("accepted sample left no live candidate");

  a_filled_sticky: assert property (@(posedge clk) disable iff (rst)
    (filled && !(s_fire && s_tlast)) |=> filled)
    else $error("window filled flag dropped mid-sequence");

endmodule
